/* rtl/hkm_pkg.sv */
package hkm_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int AW          = $clog2(MAX_SOURCES);      // entry address bits
  localparam int CW          = $clog2(MAX_SOURCES + 1);  // fill count bits
  localparam int XW          = AW + 2;                   // child index bits
  localparam int VAL_W       = 32;
  localparam int SRC_W       = 4;
  localparam int KIND_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    K_LOAD    = 2'd0,
    K_BUILD   = 2'd1,
    K_REPLACE = 2'd2,
    K_REMOVE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [SRC_W-1:0]        src;
  } entry_t;

  // microprogram steps
  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_REP_RD   = 4'd1,
    ST_REP_LD   = 4'd2,
    ST_RM_RD    = 4'd3,
    ST_RM_LD    = 4'd4,
    ST_SIFT_RD  = 4'd5,
    ST_SIFT_CMP = 4'd6,
    ST_CHK      = 4'd7,
    ST_FIN_RD   = 4'd8,
    ST_FIN      = 4'd9,
    ST_BLD_RD   = 4'd10,
    ST_BLD_LD   = 4'd11
  } step_t;

  typedef enum logic [1:0] {RA_ZERO, RA_CNT, RA_IDX, RA_CHILD} rsel_t;
  typedef enum logic [1:0] {E_HOLD, E_RDA, E_REPL} esel_t;
  typedef enum logic [2:0] {ACT_NONE, ACT_ACCEPT, ACT_BIDX, ACT_SIFT, ACT_OUT} act_t;
  typedef enum logic [2:0] {
    J_NEXT, J_ALWAYS, J_DISPATCH, J_CNT_ZERO, J_SIFT_MORE, J_BUILD_MORE
  } jmp_t;

  typedef struct packed {
    rsel_t rsel;
    esel_t esel;
    logic  pos_zero;
    act_t  act;
    jmp_t  jmp;
    step_t target;
  } ctrl_t;

  // control store: one word per step, a false jump condition falls through
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '{rsel: RA_ZERO, esel: E_HOLD, pos_zero: 1'b0, act: ACT_NONE,
          jmp: J_NEXT, target: ST_IDLE};
    unique case (s)
      ST_IDLE:     begin c.act = ACT_ACCEPT; c.jmp = J_DISPATCH; end
      ST_REP_RD:   begin c.rsel = RA_ZERO; end
      ST_REP_LD:   begin
        c.esel = E_REPL; c.pos_zero = 1'b1; c.jmp = J_ALWAYS; c.target = ST_SIFT_RD;
      end
      ST_RM_RD:    begin c.rsel = RA_CNT; end
      ST_RM_LD:    begin
        c.esel = E_RDA; c.pos_zero = 1'b1; c.jmp = J_CNT_ZERO; c.target = ST_FIN_RD;
      end
      ST_SIFT_RD:  begin c.rsel = RA_CHILD; end
      ST_SIFT_CMP: begin c.act = ACT_SIFT; c.jmp = J_SIFT_MORE; c.target = ST_SIFT_RD; end
      ST_CHK:      begin c.jmp = J_BUILD_MORE; c.target = ST_BLD_RD; end
      ST_FIN_RD:   begin c.rsel = RA_ZERO; end
      ST_FIN:      begin c.act = ACT_OUT; c.jmp = J_ALWAYS; c.target = ST_IDLE; end
      ST_BLD_RD:   begin c.rsel = RA_IDX; c.act = ACT_BIDX; end
      ST_BLD_LD:   begin c.esel = E_RDA; c.jmp = J_ALWAYS; c.target = ST_SIFT_RD; end
      default:     begin c.jmp = J_ALWAYS; c.target = ST_IDLE; end
    endcase
    return c;
  endfunction

endpackage

/* rtl/hkm_if.sv */
interface hkm_in_if import hkm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [VAL_W-1:0]  value;
  logic [SRC_W-1:0]  src;

  modport source (output valid, kind, value, src, input ready);
  modport sink   (input valid, kind, value, src, output ready);
endinterface

interface hkm_out_if import hkm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] top_value;
  logic [SRC_W-1:0] top_source;
  logic             empty_res;
  logic             error;

  modport source (output valid, top_value, top_source, empty_res, error, input ready);
  modport sink   (input valid, top_value, top_source, empty_res, error, output ready);
endinterface

/* rtl/heap_k_way_merge.sv */
// Channel  Dir  Handshake      Payload
// feed     in   valid/ready    kind[1:0], value[31:0] signed, src[3:0]
// result   out  valid/ready    top_value[31:0] signed, top_source[3:0], empty_res, error
//
// Load appends at accept. Build sifts down each internal node in turn. Replace/remove
// sift the new root down, levels <= log2(MAX_SOURCES)+1; each sift level is a child read
// plus a compare/write on the single-write heap store.
// One item at a time; feed.ready is high only while the sequencer waits at idle.
// Synchronous reset empties the heap (count to zero) and drops any pending result.
// A stalled result holds in the output register; the next item is still taken.
module heap_k_way_merge import hkm_pkg::*; (
  input logic        clk,
  input logic        rst,
  hkm_in_if.sink     feed,
  hkm_out_if.source  result
);

  entry_t          heap_mem [MAX_SOURCES];
  entry_t          rd_a, rd_b;

  step_t           step, step_next;
  ctrl_t           cw;
  logic [CW-1:0]   count;
  logic [AW-1:0]   pos, idx;
  entry_t          e;
  kind_t           kind_q;
  logic [VAL_W-1:0] value_q;
  logic            err_q;

  logic            out_valid;
  entry_t          out_top;
  logic            out_empty, out_err;

  logic            in_fire, stall, cond, full, is_empty;
  step_t           disp_target;
  kind_t           in_kind;
  logic [XW-1:0]   lch, rch;
  logic            l_lt, r_lt, more;
  logic signed [VAL_W-1:0] best_val;
  logic [AW-1:0]   ra, rb;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  entry_t          mem_wd;

  assign cw       = ucode(step);
  assign in_kind  = kind_t'(feed.kind);
  assign full     = (count == CW'(MAX_SOURCES));
  assign is_empty = (count == '0);
  assign feed.ready = (cw.act == ACT_ACCEPT);
  assign in_fire  = feed.valid && feed.ready;

  // children of the current hole
  assign lch = {1'b0, pos, 1'b1};
  assign rch = lch + XW'(1);

  assign l_lt     = (lch < XW'(count)) && ($signed(rd_a.val) < $signed(e.val));
  assign best_val = l_lt ? rd_a.val : e.val;
  assign r_lt     = (rch < XW'(count)) && ($signed(rd_b.val) < best_val);
  assign more     = l_lt || r_lt;

  assign stall = (cw.act == ACT_ACCEPT && !in_fire) ||
                 (cw.act == ACT_OUT && out_valid && !result.ready);

  always_comb begin
    unique case (in_kind)
      K_LOAD:    disp_target = ST_FIN_RD;
      K_BUILD:   disp_target = ST_CHK;
      K_REPLACE: disp_target = is_empty ? ST_FIN_RD : ST_REP_RD;
      K_REMOVE:  disp_target = is_empty ? ST_FIN_RD : ST_RM_RD;
      default:   disp_target = ST_FIN_RD;
    endcase
  end

  always_comb begin
    unique case (cw.jmp)
      J_NEXT:       cond = 1'b0;
      J_ALWAYS:     cond = 1'b1;
      J_DISPATCH:   cond = 1'b1;
      J_CNT_ZERO:   cond = is_empty;
      J_SIFT_MORE:  cond = more;
      J_BUILD_MORE: cond = (kind_q == K_BUILD) && (idx != '0);
      default:      cond = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_next = step;
    end else if (cw.jmp == J_DISPATCH) begin
      step_next = disp_target;
    end else if (cond) begin
      step_next = cw.target;
    end else begin
      step_next = step_t'(step + 4'd1);
    end
  end

  // read addresses
  always_comb begin
    unique case (cw.rsel)
      RA_ZERO:  ra = '0;
      RA_CNT:   ra = count[AW-1:0];
      RA_IDX:   ra = idx - AW'(1);
      RA_CHILD: ra = lch[AW-1:0];
      default:  ra = '0;
    endcase
    rb = rch[AW-1:0];
  end

  // write port: load append at accept, or hole fill during sift
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos;
    mem_wd = e;
    if (in_fire && in_kind == K_LOAD && !full) begin
      mem_we = 1'b1;
      mem_wa = count[AW-1:0];
      mem_wd = '{val: feed.value, src: feed.src};
    end else if (cw.act == ACT_SIFT) begin
      mem_we = 1'b1;
      mem_wa = pos;
      if (r_lt) begin
        mem_wd = rd_b;
      end else if (l_lt) begin
        mem_wd = rd_a;
      end else begin
        mem_wd = e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
    rd_a <= heap_mem[ra];
    rd_b <= heap_mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= ST_IDLE;
      count <= '0;
    end else begin
      step <= step_next;
      if (in_fire) begin
        if (in_kind == K_LOAD && !full) begin
          count <= count + CW'(1);
        end else if (in_kind == K_REMOVE && !is_empty) begin
          count <= count - CW'(1);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q  <= in_kind;
      value_q <= feed.value;
      err_q   <= (in_kind == K_LOAD) ? full :
                 ((in_kind == K_REPLACE || in_kind == K_REMOVE) && is_empty);
      idx     <= count[AW:1];
    end
    if (cw.act == ACT_BIDX) begin
      idx <= idx - AW'(1);
      pos <= idx - AW'(1);
    end
    if (cw.pos_zero) begin
      pos <= '0;
    end
    if (cw.act == ACT_SIFT) begin
      if (r_lt) begin
        pos <= rch[AW-1:0];
      end else if (l_lt) begin
        pos <= lch[AW-1:0];
      end
    end
    unique case (cw.esel)
      E_RDA:   e <= rd_a;
      E_REPL:  e <= '{val: value_q, src: rd_a.src};
      default: e <= e;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.act == ACT_OUT && !stall) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.act == ACT_OUT && !stall) begin
      out_top   <= (kind_q != K_LOAD && !is_empty) ? rd_a : '0;
      out_empty <= is_empty;
      out_err   <= err_q;
    end
  end

  assign result.valid      = out_valid;
  assign result.top_value  = out_top.val;
  assign result.top_source = out_top.src;
  assign result.empty_res  = out_empty;
  assign result.error      = out_err;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SOURCES))
    else $error("heap count beyond capacity");

  a_sift_in_heap: assert property (@(posedge clk) disable iff (rst)
    step == ST_SIFT_CMP |-> CW'(pos) < count)
    else $error("sift position outside heap");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(step) == ST_FIN)
    else $error("result raised outside final step");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !feed.ready)
    else $error("second item taken while one in flight");

endmodule
